>>> src/sthpu_pkg.sv
// sthpu_pkg: shared types, constants and filter helpers for the six-tap half-pel upsampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sthpu_pkg;

  localparam int TAPS          = 6;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int PIX_W         = 8;
  localparam int ROW_W         = 12;
  localparam int FW_W          = 11;
  localparam int SLOT_W        = 3;
  localparam int SUM_W         = 21;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [FW_W-1:0]  FW_RESET = 11'd176;
  localparam logic [ROW_W-1:0] FH_RESET = 12'd144;

  // register indexes, taken from the word address bit
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // rounding shifts of the two filter kinds
  localparam logic [3:0] SH_HALF = 4'd5;
  localparam logic [3:0] SH_CTR  = 4'd10;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef pix_t [TAPS-1:0]         col_word_t;   // one column, one byte per row slot
  typedef col_word_t [TAPS-1:0]    pix_mat_t;    // [row tap][column tap]
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [TAPS-1:0]         sum_vec_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic              last_row;
    logic              last_col;
  } pos_ctx_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
    logic             fend;
  } quad_tag_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_EMIT
  } eng_state_t;

  // taps 1,-5,20,20,-5,1
  function automatic sum_t fir6(input sum_vec_t a);
    sum_t s0;
    sum_t s1;
    sum_t s2;
    s0 = sum_t'($signed(a[0]) + $signed(a[5]));
    s1 = sum_t'($signed(a[1]) + $signed(a[4]));
    s2 = sum_t'($signed(a[2]) + $signed(a[3]));
    return sum_t'(s0 - sum_t'(5) * s1 + sum_t'(20) * s2);
  endfunction

  function automatic pix_t round_clamp(input sum_t s, input logic [3:0] sh);
    sum_t t;
    t = sum_t'(s + (sum_t'(1) <<< (sh - 4'd1))) >>> sh;
    if (s < 0) begin
      return '0;
    end
    if (t > 255) begin
      return 8'd255;
    end
    return t[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/sthpu_line_store.sv
// sthpu_line_store: column-organized line store with read-modify-write and raster counters
// depends on sthpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module sthpu_line_store #(
  parameter int  MAX_WIDTH = sthpu_pkg::DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        restart,
  input  wire logic [COL_W-1:0]            wm1,
  input  wire logic [sthpu_pkg::ROW_W-1:0] hm1,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire sthpu_pkg::pix_t             in_pixel,
  output logic                             col_valid,
  input  wire logic                        col_ready,
  output sthpu_pkg::col_word_t             col_word,
  output sthpu_pkg::pos_ctx_t              col_ctx,
  output logic [COL_W-1:0]                 col_idx
);
  import sthpu_pkg::*;

  col_word_t         mem [MAX_WIDTH];
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              s1_v_r;
  pix_t              s1_pix_r;
  pos_ctx_t          s1_ctx_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              fwd_r;
  col_word_t         rd_data_r;
  col_word_t         last_wr_r;
  col_word_t         merged;
  logic              accept;
  logic              s1_adv;
  logic              at_last_col;
  logic              at_last_row;

  assign s1_adv      = s1_v_r && col_ready;
  assign in_ready    = !s1_v_r || col_ready;
  assign accept      = in_valid && in_ready;
  assign at_last_col = col_cnt_r == wm1;
  assign at_last_row = row_cnt_r == hm1;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    slot_nxt    = slot_r;
    if (restart) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      slot_nxt    = '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt_nxt = '0;
        if (at_last_row) begin
          row_cnt_nxt = '0;
          slot_nxt    = '0;
        end else begin
          row_cnt_nxt = row_cnt_r + 1'b1;
          slot_nxt    = (slot_r == SLOT_W'(TAPS - 1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_cnt_nxt = col_cnt_r + 1'b1;
      end
    end
  end

  // back-to-back hit on the same column takes the word just written
  always_comb begin
    merged                = fwd_r ? last_wr_r : rd_data_r;
    merged[s1_ctx_r.slot] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      slot_r    <= '0;
      s1_v_r    <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      slot_r    <= slot_nxt;
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (accept) begin
        fwd_r <= s1_adv && (s1_col_r == col_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel;
      s1_col_r <= col_cnt_r;
      s1_ctx_r <= '{row: row_cnt_r, slot: slot_r, last_row: at_last_row,
                    last_col: at_last_col};
    end
    if (s1_adv) begin
      last_wr_r <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[col_cnt_r];
    end
    if (s1_adv) begin
      mem[s1_col_r] <= merged;
    end
  end

  assign col_valid = s1_v_r;
  assign col_word  = merged;
  assign col_ctx   = s1_ctx_r;
  assign col_idx   = s1_col_r;

endmodule

`default_nettype wire

>>> src/sthpu_window_seq.sv
// sthpu_window_seq: six-column window and quad sequencer, builds the 6x6 tap matrix
// depends on sthpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module sthpu_window_seq #(
  parameter int  MAX_WIDTH = sthpu_pkg::DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 col_valid,
  output logic                      col_ready,
  input  wire sthpu_pkg::col_word_t col_word,
  input  wire sthpu_pkg::pos_ctx_t  col_ctx,
  input  wire logic [COL_W-1:0]     col_idx,
  output logic                      mat_valid,
  output sthpu_pkg::pix_mat_t       mat,
  output logic [COL_W-1:0]          mat_col,
  output sthpu_pkg::quad_tag_t      mat_tag
);
  import sthpu_pkg::*;

  eng_state_t             state_r, state_nxt;
  col_word_t [TAPS-1:0]   win_r;
  pos_ctx_t               ctx_r;
  logic [COL_W-1:0]       cidx_r;
  logic [1:0]             q_r, e_r, e_start_r;
  logic [1:0]             q_end, e_end;
  logic [1:0]             q_start, e_start;
  logic                   run_done;
  logic                   issue;
  logic                   take_ok;
  logic                   col_take;
  logic                   new_emit;
  logic                   mat_v_r;
  pix_mat_t               mat_r, mat_nxt;
  logic [COL_W-1:0]       mat_col_r;
  quad_tag_t              mat_tag_r;

  assign q_end    = ctx_r.last_row ? 2'd0 : 2'd3;
  assign e_end    = ctx_r.last_col ? 2'd3 : 2'd0;
  assign run_done = (q_r == q_end) && (e_r == e_end);

  assign new_emit = (col_ctx.last_row || (col_ctx.row >= ROW_W'(3))) &&
                    (col_ctx.last_col || (col_idx >= COL_W'(3)));
  assign q_start  = (col_ctx.last_row && (col_ctx.row < ROW_W'(3))) ? col_ctx.row[1:0]
                                                                   : 2'd3;
  assign e_start  = !col_ctx.last_col ? 2'd0 :
                    (col_idx < COL_W'(3)) ? 2'd3 - col_idx[1:0] : 2'd0;

  // outputs of the sequencer
  always_comb begin
    unique case (state_r)
      ENG_IDLE: begin
        issue   = 1'b0;
        take_ok = en;
      end
      ENG_EMIT: begin
        issue   = en;
        take_ok = en && run_done;
      end
    endcase
  end

  assign col_ready = take_ok;
  assign col_take  = col_valid && take_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (col_take) begin
          state_nxt = new_emit ? ENG_EMIT : ENG_IDLE;
        end
      end
      ENG_EMIT: begin
        if (col_take) begin
          state_nxt = new_emit ? ENG_EMIT : ENG_IDLE;
        end else if (issue && run_done) begin
          state_nxt = ENG_IDLE;
        end
      end
    endcase
  end

  // tap matrix: rows by slot with clamping at the frame top and bottom,
  // columns replicate the right edge as e advances
  always_comb begin
    int b;
    int s;
    int cs;
    logic [SLOT_W-1:0] rsel [TAPS];
    logic [SLOT_W-1:0] csel [TAPS];
    for (int i = 0; i < TAPS; i++) begin
      b = int'(q_r) + 2 - i;
      if (b < 0) b = 0;
      if (b > int'(ctx_r.row)) b = int'(ctx_r.row);
      s = int'(ctx_r.slot) + TAPS - b;
      if (s >= TAPS) s = s - TAPS;
      rsel[i] = SLOT_W'(s);
      cs = i + int'(e_r);
      if (cs > TAPS - 1) cs = TAPS - 1;
      csel[i] = SLOT_W'(cs);
    end
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        mat_nxt[i][j] = win_r[csel[j]][rsel[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ENG_IDLE;
      q_r       <= '0;
      e_r       <= '0;
      e_start_r <= '0;
      mat_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (col_take) begin
        q_r       <= q_start;
        e_r       <= e_start;
        e_start_r <= e_start;
      end else if (issue && !run_done) begin
        if (e_r == e_end) begin
          e_r <= e_start_r;
          q_r <= q_r - 1'b1;
        end else begin
          e_r <= e_r + 1'b1;
        end
      end
      if (en) begin
        mat_v_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_take) begin
      ctx_r  <= col_ctx;
      cidx_r <= col_idx;
      if (col_idx == '0) begin
        for (int k = 0; k < TAPS; k++) begin
          win_r[k] <= col_word;
        end
      end else begin
        for (int k = 0; k < TAPS - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[TAPS-1] <= col_word;
      end
    end
    if (issue) begin
      mat_r          <= mat_nxt;
      mat_col_r      <= COL_W'(cidx_r + COL_W'(e_r) - COL_W'(3));
      mat_tag_r.row  <= ROW_W'(ctx_r.row - ROW_W'(q_r));
      mat_tag_r.last <= run_done;
      mat_tag_r.fend <= ctx_r.last_row && ctx_r.last_col && (q_r == 2'd0) && (e_r == 2'd3);
    end
  end

  assign mat_valid = mat_v_r;
  assign mat       = mat_r;
  assign mat_col   = mat_col_r;
  assign mat_tag   = mat_tag_r;

endmodule

`default_nettype wire

>>> src/sthpu_filter.sv
// sthpu_filter: separable six-tap filter pipeline and output register
// depends on sthpu_pkg
`timescale 1ns / 1ps
`default_nettype none

module sthpu_filter #(
  parameter int  MAX_WIDTH = sthpu_pkg::DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  output logic                             en,
  input  wire logic                        mat_valid,
  input  wire sthpu_pkg::pix_mat_t         mat,
  input  wire logic [COL_W-1:0]            mat_col,
  input  wire sthpu_pkg::quad_tag_t        mat_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [sthpu_pkg::ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]                 out_col,
  output sthpu_pkg::pix_t                  out_full,
  output sthpu_pkg::pix_t                  out_half_h,
  output sthpu_pkg::pix_t                  out_half_v,
  output sthpu_pkg::pix_t                  out_center,
  output logic                             out_last,
  output logic                             out_fend
);
  import sthpu_pkg::*;

  logic             b_v_r;
  sum_vec_t         rs_r, rs_c;
  sum_t             vs_r, vs_c;
  pix_t             full_r;
  logic [COL_W-1:0] bcol_r;
  quad_tag_t        btag_r;
  logic             o_v_r;
  logic [COL_W-1:0] ocol_r;
  quad_tag_t        otag_r;
  pix_t             ofull_r, oh_r, ov_r, oc_r;
  sum_t             csum;

  assign en = !o_v_r || out_ready;

  // row sums of the matrix and the vertical sum down the center column
  always_comb begin
    sum_vec_t tmp;
    sum_vec_t vcol;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        tmp[j] = sum_t'(mat[i][j]);
      end
      rs_c[i] = fir6(tmp);
      vcol[i] = sum_t'(mat[i][2]);
    end
    vs_c = fir6(vcol);
  end

  assign csum = fir6(rs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= mat_valid;
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r    <= rs_c;
      vs_r    <= vs_c;
      full_r  <= mat[2][2];
      bcol_r  <= mat_col;
      btag_r  <= mat_tag;
      ocol_r  <= bcol_r;
      otag_r  <= btag_r;
      ofull_r <= full_r;
      oh_r    <= round_clamp(rs_r[2], SH_HALF);
      ov_r    <= round_clamp(vs_r, SH_HALF);
      oc_r    <= round_clamp(csum, SH_CTR);
    end
  end

  assign out_valid  = o_v_r;
  assign out_row    = otag_r.row;
  assign out_col    = ocol_r;
  assign out_full   = ofull_r;
  assign out_half_h = oh_r;
  assign out_half_v = ov_r;
  assign out_center = oc_r;
  assign out_last   = otag_r.last;
  assign out_fend   = otag_r.fend;

endmodule

`default_nettype wire

>>> src/six_tap_half_pel_upsampler_top.sv
// released quads pass the line store, window, tap matrix, row-sum and output registers
// throughput: one pixel and one quad per cycle inside a frame while the output is taken;
//   the quad sequencer issues one quad per cycle, so a row end, a last-row pixel and the
//   final pixel of the frame stall the input while their extra quads are issued
// reset: raster counters cleared, frame_width 176 and frame_height 144; the line store
//   is not cleared and holds no valid bits, every read entry is written earlier in the frame
`timescale 1ns / 1ps
`default_nettype none

module six_tap_half_pel_upsampler_top #(
  parameter int  MAX_WIDTH = sthpu_pkg::DEF_MAX_WIDTH,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int OUT_DW    = ((sthpu_pkg::ROW_W + COL_W + 4 * sthpu_pkg::PIX_W + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [sthpu_pkg::PIX_W-1:0]  in_tdata,     // pixel_in
  // result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // quad_row, quad_col, pix_full, pix_half_h, pix_half_v, pix_center, zero fill
  output logic [OUT_DW-1:0]                 out_tdata,
  output logic                              out_tlast,    // last_of_run
  output logic                              out_tuser,    // frame_end
  // configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [sthpu_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [sthpu_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sthpu_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                              cfg_pready
);
  import sthpu_pkg::*;

  logic [FW_W-1:0]  frame_width_r;
  logic [ROW_W-1:0] frame_height_r;
  logic             cfg_wr;
  logic             reg_idx;
  logic [COL_W-1:0] wm1;
  logic [ROW_W-1:0] hm1;

  // line store to sequencer
  logic             col_valid;
  logic             col_ready;
  col_word_t        col_word;
  pos_ctx_t         col_ctx;
  logic [COL_W-1:0] col_idx;

  // sequencer to filter
  logic             en;
  logic             mat_valid;
  pix_mat_t         mat;
  logic [COL_W-1:0] mat_col;
  quad_tag_t        mat_tag;

  // result fields
  logic [ROW_W-1:0] q_row;
  logic [COL_W-1:0] q_col;
  pix_t             p_full, p_h, p_v, p_c;

  // apb register file, word address bit selects the register
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == REG_FRAME_HEIGHT) ? CFG_DW'(frame_height_r)
                                                    : CFG_DW'(frame_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == REG_FRAME_HEIGHT) begin
        frame_height_r <= cfg_pwdata[ROW_W-1:0];
      end else begin
        frame_width_r <= cfg_pwdata[FW_W-1:0];
      end
    end
  end

  // effective last column and last row: zero counts as one, width saturates
  always_comb begin
    if (frame_width_r == '0) begin
      wm1 = '0;
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(frame_width_r - 1'b1);
    end
    hm1 = (frame_height_r == '0) ? '0 : frame_height_r - 1'b1;
  end

  // pixel write and column read-modify-write, one column word per address
  sthpu_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_wr),
    .wm1       (wm1),
    .hm1       (hm1),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_word  (col_word),
    .col_ctx   (col_ctx),
    .col_idx   (col_idx)
  );

  // sliding six-column window and the burst walk over released quads
  sthpu_window_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col_word  (col_word),
    .col_ctx   (col_ctx),
    .col_idx   (col_idx),
    .mat_valid (mat_valid),
    .mat       (mat),
    .mat_col   (mat_col),
    .mat_tag   (mat_tag)
  );

  // row sums, then center sum and rounding into the output register
  sthpu_filter #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .mat_valid  (mat_valid),
    .mat        (mat),
    .mat_col    (mat_col),
    .mat_tag    (mat_tag),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (q_row),
    .out_col    (q_col),
    .out_full   (p_full),
    .out_half_h (p_h),
    .out_half_v (p_v),
    .out_center (p_c),
    .out_last   (out_tlast),
    .out_fend   (out_tuser)
  );

  assign out_tdata = OUT_DW'({p_c, p_v, p_h, p_full, q_col, q_row});

`ifndef SYNTHESIS
  a_fend_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end quad not marked as last of its run");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> q_col <= wm1)
    else $error("quad column beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> q_row <= hm1)
    else $error("quad row beyond frame height");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// testbench for the six-tap half-pel upsampler: streams pixel frames under many sizes,
// predicts every quad in place and checks each one field by field as it leaves
// depends on sthpu_pkg and six_tap_half_pel_upsampler_top
`timescale 1ns / 1ps

module testbench;
  import sthpu_pkg::*;

  localparam int MAXW     = 1024;
  localparam int OUT_DW   = 56;
  localparam int LIMIT    = 1500000;
  localparam int SETTLE   = 30;       // margin for the quad pipeline; bursts run up to 16 quads
  localparam int HOLD_LEN = 400;
  localparam int MAX_MSGS = 60;

  // byte addresses of the two registers
  localparam logic [CFG_AW-1:0] ADDR_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_FRAME_HEIGHT = 3'd4;

  // idling modes, cycled per phase
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [7:0]  full;
    logic [7:0]  half_h;
    logic [7:0]  half_v;
    logic [7:0]  center;
    logic        last;
    logic        fend;
  } quad_t;

  // directed rows: frame size, pixel, and a typed-in expectation where obvious
  typedef struct {
    int       w;
    int       h;
    bit [7:0] pix;
    bit       typed;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;      // pixel_in
  logic              out_tvalid;
  logic              out_tready;
  // quad_row, quad_col, pix_full, pix_half_h, pix_half_v, pix_center, zero fill
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;     // last_of_run
  logic              out_tuser;     // frame_end
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  six_tap_half_pel_upsampler_top DUT (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state: its own line store, raster position and registers
  logic [7:0]  line_mem [TAPS][MAXW];
  int          next_row;
  int          next_col;
  logic [10:0] width_reg;
  logic [11:0] height_reg;
  quad_t       pending_quads[$];

  int  errors;
  int  msgs;
  int  cyc;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_from;
  bit  typed_now;
  quad_t typed_quad;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // clamped tap fetch
  function automatic int pel(int y, int x, int h, int w);
    if (y < 0) y = 0;
    if (y > h - 1) y = h - 1;
    if (x < 0) x = 0;
    if (x > w - 1) x = w - 1;
    return line_mem[y % TAPS][x];
  endfunction

  function automatic logic [7:0] round_sat(int s, int sh);
    int v;
    if (s < 0) return 8'd0;
    v = (s + (1 << (sh - 1))) >>> sh;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // store one pixel and queue every quad it completes
  task automatic interpolate_pixel(logic [7:0] p);
    int coef [TAPS] = '{1, -5, 20, 20, -5, 1};
    int w, h, r, c, ylo, yhi, xlo, xhi, sh, sv, sc, acc;
    quad_t q;
    w = eff_w();
    h = eff_h();
    r = next_row;
    c = next_col;
    line_mem[r % TAPS][c] = p;
    if (r == h - 1) begin
      ylo = (r >= 3) ? r - 3 : 0;
      yhi = r;
    end else begin
      ylo = r - 3;
      yhi = r - 3;
    end
    if (c == w - 1) begin
      xlo = (c >= 3) ? c - 3 : 0;
      xhi = c;
    end else begin
      xlo = c - 3;
      xhi = c - 3;
    end
    if (ylo >= 0 && xlo >= 0) begin
      for (int y = ylo; y <= yhi; y++) begin
        for (int x = xlo; x <= xhi; x++) begin
          sh = 0;
          sv = 0;
          sc = 0;
          for (int i = 0; i < TAPS; i++) begin
            acc = 0;
            for (int j = 0; j < TAPS; j++) acc += coef[j] * pel(y - 2 + i, x - 2 + j, h, w);
            sc += coef[i] * acc;
            sh += coef[i] * pel(y, x - 2 + i, h, w);
            sv += coef[i] * pel(y - 2 + i, x, h, w);
          end
          q.row    = y[11:0];
          q.col    = x[9:0];
          q.full   = 8'(pel(y, x, h, w));
          q.half_h = round_sat(sh, 5);
          q.half_v = round_sat(sv, 5);
          q.center = round_sat(sc, 10);
          q.last   = (y == yhi && x == xhi);
          q.fend   = (y == h - 1 && x == w - 1);
          pending_quads.push_back(q);
        end
      end
    end
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      if (msgs < MAX_MSGS) begin
        msgs++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    end
  endtask

  // run limit and the long receiver hold-off share this cycle count
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off window
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (cyc >= hold_from && cyc < hold_from + HOLD_LEN) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on every pixel transaction, check every quad transaction
  always @(posedge clk) begin
    quad_t e;
    if (rst_n && in_tvalid && in_tready) begin
      int n_prior;
      n_prior = pending_quads.size();
      interpolate_pixel(in_tdata);
      if (typed_now) begin
        while (pending_quads.size() > n_prior) void'(pending_quads.pop_back());
        pending_quads.push_back(typed_quad);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_quads.size() == 0) begin
        errors++;
        if (msgs < MAX_MSGS) begin
          msgs++;
          $display("%0t ns: unexpected quad, expected none, actual %h", $time, out_tdata);
        end
      end else begin
        e = pending_quads.pop_front();
        check_field("quad_row",    int'(e.row),    int'(out_tdata[11:0]));
        check_field("quad_col",    int'(e.col),    int'(out_tdata[21:12]));
        check_field("pix_full",    int'(e.full),   int'(out_tdata[29:22]));
        check_field("pix_half_h",  int'(e.half_h), int'(out_tdata[37:30]));
        check_field("pix_half_v",  int'(e.half_v), int'(out_tdata[45:38]));
        check_field("pix_center",  int'(e.center), int'(out_tdata[53:46]));
        check_field("last_of_run", int'(e.last),   int'(out_tlast));
        check_field("frame_end",   int'(e.fend),   int'(out_tuser));
      end
    end
  end

  // setup then access cycle; the register takes the value at the access edge
  task automatic reg_write(logic [CFG_AW-1:0] addr, int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_FRAME_WIDTH) width_reg = value[10:0];
    else height_reg = value[11:0];
    next_row = 0;
    next_col = 0;
  endtask

  // let every expected quad drain, then the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    reg_write(ADDR_FRAME_WIDTH, w);
    reg_write(ADDR_FRAME_HEIGHT, h);
  endtask

  task automatic set_idling(int mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 12 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 12 : 0;
  endtask

  // one pixel transaction; each cycle idles with the sender's idle odds
  task automatic send_pixel(logic [7:0] p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
  endtask

  // pixel mix: smooth, full-scale swings and uniform noise
  function automatic logic [7:0] rand_pixel(logic [7:0] prev);
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8'd255 : 8'd0;
      1:       return prev + 8'($urandom_range(16)) - 8'd8;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixels(int n);
    logic [7:0] p;
    p = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      p = rand_pixel(p);
      send_pixel(p);
    end
  endtask

  stim_row_t directed [24];

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    errors         = 0;
    msgs           = 0;
    cyc            = 0;
    hold_from      = 32'h7fff_ffff;
    typed_now      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    width_reg      = 11'd176;
    height_reg     = 12'd144;
    next_row       = 0;
    next_col       = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = 8'd0;

    // a one-pixel frame copies the pixel into all four outputs;
    // a 4x4 checkerboard drives sums negative and past full scale
    foreach (directed[k]) begin
      if (k < 8) begin
        directed[k] = '{1, 1, 8'(k == 0 ? 0 : k == 1 ? 255 : 1 << (k - 1)), 1'b1};
      end else begin
        directed[k] = '{4, 4, (((k - 8) ^ ((k - 8) >> 2)) & 1) ? 8'd255 : 8'd0, 1'b0};
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; the typed expectation changes only after the monitor has seen
    // the previous pixel's transaction
    set_idling(IDLE_NONE);
    foreach (directed[k]) begin
      if (directed[k].w != eff_w() || directed[k].h != eff_h() || k == 0)
        set_frame(directed[k].w, directed[k].h);
      typed_quad <= '{12'd0, 10'd0, directed[k].pix, directed[k].pix, directed[k].pix,
                      directed[k].pix, 1'b1, 1'b1};
      typed_now  <= directed[k].typed;
      send_pixel(directed[k].pix);
    end
    drain();
    typed_now <= 1'b0;

    // register extremes: zero size, oversized width, widest and tallest frames
    set_idling(IDLE_BOTH);
    set_frame(0, 0);
    send_pixels(2);
    set_frame(2047, 1);
    send_pixels(48);
    set_frame(1024, 1);
    set_idling(IDLE_RECV);
    send_pixels(40);
    set_frame(1, 4095);
    set_idling(IDLE_NONE);
    send_pixels(40);

    // long receiver hold-off while the sender keeps pushing
    set_frame(8, 6);
    hold_from = cyc + 5;
    send_pixels(96);

    // random frames: mostly whole frames, sometimes cut short by a register write
    for (int ph = 0; ph < 8; ph++) begin
      int w, h;
      set_idling(ph % 4);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      if ($urandom_range(9) == 0) w = $urandom_range(0, 2047) & 11'h00f;
      set_frame(w, h);
      send_pixels(eff_w() * eff_h() * $urandom_range(1, 2));
      if ($urandom_range(3) == 0) send_pixels($urandom_range(1, eff_w() * eff_h()));
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sthpu_pkg.sv
src/sthpu_line_store.sv
src/sthpu_window_seq.sv
src/sthpu_filter.sv
src/six_tap_half_pel_upsampler_top.sv
sim/testbench.sv
